// ===== rtl/fdsa_pkg.sv =====
`timescale 1ns / 1ps

package fdsa_pkg;

    typedef enum logic [3:0] {
        FN_PUSH  = 4'd0,
        FN_DUP   = 4'd1,
        FN_SWAP  = 4'd2,
        FN_ADD   = 4'd3,
        FN_SUB   = 4'd4,
        FN_MUL   = 4'd5,
        FN_DIV   = 4'd6,
        FN_MOD   = 4'd7,
        FN_PRINT = 4'd8
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MD_MUL = 2'd0,
        MD_DIV = 2'd1,
        MD_MOD = 2'd2
    } md_op_t;

    typedef struct packed {
        logic   start;
        md_op_t op;
    } md_ctrl_t;

    // microcode fields
    typedef enum logic [1:0] {
        RD_NONE = 2'd0,
        RD_TOP  = 2'd1,
        RD_SEC  = 2'd2
    } rd_t;

    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_SP   = 2'd1,
        WR_TOP  = 2'd2,
        WR_SEC  = 2'd3
    } wr_t;

    typedef enum logic [1:0] {
        WS_LIT = 2'd0,
        WS_T   = 2'd1,
        WS_S   = 2'd2,
        WS_RES = 2'd3
    } wsrc_t;

    typedef enum logic [1:0] {
        SP_HOLD = 2'd0,
        SP_INC  = 2'd1,
        SP_DEC  = 2'd2
    } spop_t;

    typedef enum logic [2:0] {
        JMP_NEXT  = 3'd0,
        JMP_DONE  = 3'd1,
        JMP_FAST  = 3'd2,
        JMP_TZERO = 3'd3,
        JMP_WAIT  = 3'd4
    } jmp_t;

    typedef logic [4:0] upc_t;

    typedef struct packed {
        rd_t     rd;
        logic    ldt;
        logic    lds;
        wr_t     wr;
        wsrc_t   wsrc;
        spop_t   sp;
        logic    start;
        logic    pv;
        status_t st;
        jmp_t    jmp;
        upc_t    target;
    } cw_t;

    localparam upc_t UA_PUSH = 5'd0;
    localparam upc_t UA_DUP0 = 5'd1;
    localparam upc_t UA_DUP1 = 5'd2;
    localparam upc_t UA_DUP2 = 5'd3;
    localparam upc_t UA_SWP0 = 5'd4;
    localparam upc_t UA_SWP1 = 5'd5;
    localparam upc_t UA_SWP2 = 5'd6;
    localparam upc_t UA_SWP3 = 5'd7;
    localparam upc_t UA_SWP4 = 5'd8;
    localparam upc_t UA_BIN0 = 5'd9;
    localparam upc_t UA_BIN1 = 5'd10;
    localparam upc_t UA_BIN2 = 5'd11;
    localparam upc_t UA_BIN3 = 5'd12;
    localparam upc_t UA_BIN4 = 5'd13;
    localparam upc_t UA_BIN5 = 5'd14;
    localparam upc_t UA_BINW = 5'd15;
    localparam upc_t UA_PRT0 = 5'd16;
    localparam upc_t UA_PRT1 = 5'd17;
    localparam upc_t UA_PRT2 = 5'd18;
    localparam upc_t UA_DIVZ = 5'd19;
    localparam upc_t UA_UNDR = 5'd20;
    localparam upc_t UA_OVER = 5'd21;
    localparam upc_t UA_NOP  = 5'd22;

    localparam upc_t UA_LAST = UA_NOP;

    function automatic cw_t ucode(input upc_t a);
        cw_t w;
        begin
            w = '0;
            case (a)
                UA_PUSH:
                begin
                    w.wr = WR_SP; w.wsrc = WS_LIT; w.sp = SP_INC; w.jmp = JMP_DONE;
                end
                UA_DUP0: w.rd = RD_TOP;
                UA_DUP1: w.ldt = 1'b1;
                UA_DUP2:
                begin
                    w.wr = WR_SP; w.wsrc = WS_T; w.sp = SP_INC; w.jmp = JMP_DONE;
                end
                UA_SWP0: w.rd = RD_TOP;
                UA_SWP1:
                begin
                    w.rd = RD_SEC; w.ldt = 1'b1;
                end
                UA_SWP2: w.lds = 1'b1;
                UA_SWP3:
                begin
                    w.wr = WR_TOP; w.wsrc = WS_S;
                end
                UA_SWP4:
                begin
                    w.wr = WR_SEC; w.wsrc = WS_T; w.jmp = JMP_DONE;
                end
                UA_BIN0: w.rd = RD_TOP;
                UA_BIN1:
                begin
                    w.rd = RD_SEC; w.ldt = 1'b1;
                end
                UA_BIN2:
                begin
                    w.lds = 1'b1; w.jmp = JMP_FAST; w.target = UA_BINW;
                end
                UA_BIN3:
                begin
                    w.jmp = JMP_TZERO; w.target = UA_DIVZ;
                end
                UA_BIN4: w.start = 1'b1;
                UA_BIN5: w.jmp = JMP_WAIT;
                UA_BINW:
                begin
                    w.wr = WR_SEC; w.wsrc = WS_RES; w.sp = SP_DEC; w.jmp = JMP_DONE;
                end
                UA_PRT0: w.rd = RD_TOP;
                UA_PRT1: w.ldt = 1'b1;
                UA_PRT2:
                begin
                    w.pv = 1'b1; w.sp = SP_DEC; w.jmp = JMP_DONE;
                end
                UA_DIVZ:
                begin
                    w.st = ST_DIVZ; w.jmp = JMP_DONE;
                end
                UA_UNDR:
                begin
                    w.st = ST_UNDER; w.jmp = JMP_DONE;
                end
                UA_OVER:
                begin
                    w.st = ST_OVER; w.jmp = JMP_DONE;
                end
                default: w.jmp = JMP_DONE;
            endcase
            return w;
        end
    endfunction

endpackage

// ===== rtl/fdsa_cmd_if.sv =====
`timescale 1ns / 1ps

interface fdsa_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  func;
    logic [31:0] literal;

    modport source (output valid, output func, output literal, input ready);
    modport sink (input valid, input func, input literal, output ready);
endinterface

// ===== rtl/fdsa_res_if.sv =====
`timescale 1ns / 1ps

interface fdsa_res_if;
    logic        valid;
    logic        ready;
    logic        print_valid;
    logic [31:0] print_value;
    logic [1:0]  status;
    logic [6:0]  depth;

    modport source (output valid, output print_valid, output print_value,
                    output status, output depth, input ready);
    modport sink (input valid, input print_valid, input print_value,
                  input status, input depth, output ready);
endinterface

// ===== rtl/fdsa_muldiv.sv =====
`timescale 1ns / 1ps

module fdsa_muldiv
    import fdsa_pkg::*;
#(
    parameter int DW = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  md_ctrl_t      ctrl,
    input  logic [DW-1:0] s,
    input  logic [DW-1:0] t,
    output logic          busy,
    output logic [DW-1:0] result
);

    localparam int CW = $clog2(DW);

    typedef enum logic [2:0] {
        MS_IDLE = 3'b001,
        MS_RUN  = 3'b010,
        MS_FIX  = 3'b100
    } md_state_t;

    md_state_t     state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    md_op_t        op_reg;
    logic          sneg_reg, tneg_reg;
    logic [DW:0]   acc_reg;
    logic [DW-1:0] opa_reg, opb_reg, result_reg;
    logic [DW:0]   rem_shift, diff;
    logic [DW-1:0] neg_opa, neg_rem;

    // opa: multiplicand / dividend-then-quotient; opb: multiplier / divisor
    assign rem_shift = {acc_reg[DW-1:0], opa_reg[DW-1]};
    assign diff      = rem_shift - {1'b0, opb_reg};
    assign neg_opa   = '0 - opa_reg;
    assign neg_rem   = '0 - acc_reg[DW-1:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            MS_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = MS_RUN;
                    cnt_next   = '0;
                end
            end
            MS_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1))
                begin
                    state_next = MS_FIX;
                end
            end
            MS_FIX:  state_next = MS_IDLE;
            default: state_next = MS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            MS_IDLE:
            begin
                if (ctrl.start)
                begin
                    op_reg   <= ctrl.op;
                    sneg_reg <= s[DW-1];
                    tneg_reg <= t[DW-1];
                    acc_reg  <= '0;
                    opa_reg  <= (ctrl.op != MD_MUL && s[DW-1]) ? ('0 - s) : s;
                    opb_reg  <= (ctrl.op != MD_MUL && t[DW-1]) ? ('0 - t) : t;
                end
            end
            MS_RUN:
            begin
                if (op_reg == MD_MUL)
                begin
                    if (opb_reg[0])
                    begin
                        acc_reg <= {1'b0, acc_reg[DW-1:0] + opa_reg};
                    end
                    opa_reg <= {opa_reg[DW-2:0], 1'b0};
                    opb_reg <= {1'b0, opb_reg[DW-1:1]};
                end
                else if (!diff[DW])
                begin
                    acc_reg <= diff;
                    opa_reg <= {opa_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    acc_reg <= rem_shift;
                    opa_reg <= {opa_reg[DW-2:0], 1'b0};
                end
            end
            MS_FIX:
            begin
                case (op_reg)
                    MD_MUL:  result_reg <= acc_reg[DW-1:0];
                    MD_DIV:  result_reg <= (sneg_reg ^ tneg_reg) ? neg_opa : opa_reg;
                    MD_MOD:  result_reg <= sneg_reg ? neg_rem : acc_reg[DW-1:0];
                    default: result_reg <= acc_reg[DW-1:0];
                endcase
            end
            default: ;
        endcase
    end

    assign busy   = (state_reg != MS_IDLE);
    assign result = result_reg;

    a_md_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == MS_IDLE && ctrl.start) |=> (state_reg == MS_RUN && cnt_reg == '0))
    else $error("muldiv did not start a run");

    a_md_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == MS_FIX) |=> (state_reg == MS_IDLE))
    else $error("muldiv stuck after fix-up");

    a_md_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == MS_RUN && cnt_reg != CW'(DW - 1)) |=> (state_reg == MS_RUN))
    else $error("muldiv left run early");

endmodule

// ===== rtl/forth_data_stack_alu_top.sv =====
`timescale 1ns / 1ps

// channel  dir  payload                                   role
// cmd      in   func[3:0], literal[31:0]                  one operation per beat
// res      out  print_valid, print_value[31:0],           one result per operation
//               status[1:0], depth[6:0]
//
// One operation in flight, sequenced by a microcode ROM.
// Add/sub skip the iterative shift unit; mul/div/mod wait on it, and divide by zero
// is caught before it starts. Underflow, overflow and unused codes only report status.
// Reset clears the stack pointer, busy flag, microstep and res valid; the stack RAM (registered read) is not cleared.
// A stalled res beat holds the final microstep; cmd is taken once that step retires.

module forth_data_stack_alu_top
    import fdsa_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    fdsa_cmd_if.sink   cmd,
    fdsa_res_if.source res
);

    localparam int DW  = DATA_WIDTH;
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    logic [DW-1:0]  mem [0:STACK_DEPTH-1];

    logic [SPW-1:0] sp_reg, sp_next, sp_m1, sp_m2;
    logic           busy_reg, busy_next;
    upc_t           upc_reg, upc_next, entry;
    func_t          func_reg;
    logic [DW-1:0]  lit_reg, t_reg, s_reg, rdata_reg;
    logic [DW-1:0]  wdata, alu_res, md_result;
    logic [AW-1:0]  rd_addr, wr_addr;
    logic [DW+31:0] lit_ext;
    logic [DW+31:0] pv_ext;
    logic [SPW+6:0] dep_ext;
    cw_t            cw;
    logic           go, accept, done, cond;
    logic           sp_empty, sp_lt2, sp_full;
    md_ctrl_t       md_ctrl;
    logic           md_busy;

    logic           out_valid_reg, out_valid_next;
    logic           pvalid_reg;
    logic [31:0]    pvalue_reg;
    status_t        status_reg;
    logic [6:0]     depth_reg;

    assign sp_m1    = sp_reg - 1'b1;
    assign sp_m2    = sp_reg - SPW'(2);
    assign sp_empty = (sp_reg == '0);
    assign sp_lt2   = (sp_reg < SPW'(2));
    assign sp_full  = (sp_reg == SPW'(STACK_DEPTH));

    assign cmd.ready = !busy_reg;
    assign accept    = cmd.valid && !busy_reg;

    assign cw   = ucode(upc_reg);
    assign done = (cw.jmp == JMP_DONE);
    assign go   = busy_reg && !(done && out_valid_reg && !res.ready);

    always_comb
    begin
        case (func_t'(cmd.func))
            FN_PUSH:  entry = sp_full ? UA_OVER : UA_PUSH;
            FN_DUP:   entry = sp_empty ? UA_UNDR : (sp_full ? UA_OVER : UA_DUP0);
            FN_SWAP:  entry = sp_lt2 ? UA_UNDR : UA_SWP0;
            FN_ADD,
            FN_SUB,
            FN_MUL,
            FN_DIV,
            FN_MOD:   entry = sp_lt2 ? UA_UNDR : UA_BIN0;
            FN_PRINT: entry = sp_empty ? UA_UNDR : UA_PRT0;
            default:  entry = UA_NOP;
        endcase
    end

    always_comb
    begin
        case (cw.jmp)
            JMP_FAST:  cond = (func_reg == FN_ADD || func_reg == FN_SUB);
            JMP_TZERO: cond = (func_reg == FN_DIV || func_reg == FN_MOD) && (t_reg == '0);
            JMP_WAIT:  cond = md_busy;
            default:   cond = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            upc_next  = entry;
        end
        else if (go)
        begin
            case (cw.jmp)
                JMP_DONE:  busy_next = 1'b0;
                JMP_WAIT:  upc_next  = cond ? upc_reg : upc_reg + 1'b1;
                JMP_FAST,
                JMP_TZERO: upc_next  = cond ? cw.target : upc_reg + 1'b1;
                default:   upc_next  = upc_reg + 1'b1;
            endcase
        end
    end

    always_comb
    begin
        sp_next = sp_reg;
        if (go)
        begin
            case (cw.sp)
                SP_INC:  sp_next = sp_reg + 1'b1;
                SP_DEC:  sp_next = sp_m1;
                default: sp_next = sp_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go && done)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            busy_reg      <= 1'b0;
            upc_reg       <= UA_NOP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg        <= sp_next;
            busy_reg      <= busy_next;
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign lit_ext = {{DW{cmd.literal[31]}}, cmd.literal};
    assign pv_ext  = {{32{t_reg[DW-1]}}, t_reg};
    assign dep_ext = {7'd0, sp_next};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func_t'(cmd.func);
            lit_reg  <= lit_ext[DW-1:0];
        end
        if (go && cw.ldt)
        begin
            t_reg <= rdata_reg;
        end
        if (go && cw.lds)
        begin
            s_reg <= rdata_reg;
        end
        if (go && done)
        begin
            pvalid_reg <= cw.pv;
            pvalue_reg <= cw.pv ? pv_ext[31:0] : 32'd0;
            status_reg <= cw.st;
            depth_reg  <= dep_ext[6:0];
        end
    end

    // stack RAM
    assign rd_addr = (cw.rd == RD_SEC) ? sp_m2[AW-1:0] : sp_m1[AW-1:0];

    always_comb
    begin
        case (cw.wr)
            WR_TOP:  wr_addr = sp_m1[AW-1:0];
            WR_SEC:  wr_addr = sp_m2[AW-1:0];
            default: wr_addr = sp_reg[AW-1:0];
        endcase
    end

    assign alu_res = (func_reg == FN_SUB) ? (s_reg - t_reg) :
                     (func_reg == FN_ADD) ? (s_reg + t_reg) : md_result;

    always_comb
    begin
        case (cw.wsrc)
            WS_T:    wdata = t_reg;
            WS_S:    wdata = s_reg;
            WS_RES:  wdata = alu_res;
            default: wdata = lit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (go && cw.wr != WR_NONE)
        begin
            mem[wr_addr] <= wdata;
        end
        if (go && cw.rd != RD_NONE)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        md_ctrl.start = go && cw.start;
        case (func_reg)
            FN_DIV:  md_ctrl.op = MD_DIV;
            FN_MOD:  md_ctrl.op = MD_MOD;
            default: md_ctrl.op = MD_MUL;
        endcase
    end

    fdsa_muldiv #(
        .DW (DW)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (md_ctrl),
        .s      (s_reg),
        .t      (t_reg),
        .busy   (md_busy),
        .result (md_result)
    );

    assign res.valid       = out_valid_reg;
    assign res.print_valid = pvalid_reg;
    assign res.print_value = pvalue_reg;
    assign res.status      = status_reg;
    assign res.depth       = depth_reg;

    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

    a_md_take: assert property (@(posedge clk) disable iff (!rst_n)
        md_ctrl.start |=> md_busy)
    else $error("muldiv unit did not take start");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (go && done) |=> (depth_reg == dep_ext[6:0]))
    else $error("reported depth differs from stack pointer");

    a_sp_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(sp_reg) |-> $past(busy_reg))
    else $error("stack pointer moved while idle");

    a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (upc_reg <= UA_LAST))
    else $error("microstep out of range");

endmodule
